// ----- rtl/hog_gradient_orientation_core_defines.svh -----
// Assertion macros used by the checker file of the gradient orientation core.
// No dependencies; each macro expects clk and rst in the enclosing scope.
`ifndef HOG_GRADIENT_ORIENTATION_CORE_DEFINES_SVH
`define HOG_GRADIENT_ORIENTATION_CORE_DEFINES_SVH

// same-cycle implication
`define HGO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HGO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/hgo_pkg.sv -----
// Shared types, constants and direction tables of the gradient orientation core.
// No dependencies; used by every other file of the block but the defines header.
package hgo_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = 12;
  localparam int HEIGHT_W  = 16;
  localparam int CH_W      = 8;
  localparam int NCH       = 3;
  localparam int PIX_W     = CH_W * NCH;
  localparam int DIFF_W    = CH_W + 1;
  localparam int MAG_W     = 9;
  localparam int BIN_W     = 5;
  localparam int DIRS      = 9;
  localparam int IDX_W     = 4;
  localparam int COEF_W    = 15;
  localparam int DOT_W     = 24;
  localparam int BEST_W    = DOT_W - 1;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int BIN_MAX   = 2 * DIRS - 1;
  localparam int MAG_MAX   = 2 * ((1 << CH_W) - 1);

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [2:0] wcol_t;   // [0] two rows up, [2] current row

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [MAG_W-1:0]         mag;
  } grad_t;

  typedef struct packed {
    logic                     valid;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [MAG_W-1:0]         mag;
    logic signed [DOT_W-1:0]  dot;
    logic [BEST_W-1:0]        peak_dot;
    logic [BIN_W-1:0]         best_o;
  } ocell_t;

  // unit vectors scaled by 10000
  localparam logic signed [COEF_W-1:0] DIR_U [DIRS] = '{
    15'sd10000, 15'sd9397, 15'sd7660, 15'sd5000, 15'sd1736,
    -15'sd1736, -15'sd5000, -15'sd7660, -15'sd9397
  };
  localparam logic signed [COEF_W-1:0] DIR_V [DIRS] = '{
    15'sd0, 15'sd3420, 15'sd6428, 15'sd8660, 15'sd9848,
    15'sd9848, 15'sd8660, 15'sd6428, 15'sd3420
  };

  function automatic logic signed [COEF_W-1:0] dir_u(input logic [IDX_W-1:0] k);
    logic signed [COEF_W-1:0] r;
    r = '0;
    if (k < IDX_W'(DIRS)) r = DIR_U[k];
    return r;
  endfunction

  function automatic logic signed [COEF_W-1:0] dir_v(input logic [IDX_W-1:0] k);
    logic signed [COEF_W-1:0] r;
    r = '0;
    if (k < IDX_W'(DIRS)) r = DIR_V[k];
    return r;
  endfunction

  function automatic logic signed [DOT_W-1:0] dot_of(input logic [IDX_W-1:0] k,
                                                      input logic signed [DIFF_W-1:0] dx,
                                                      input logic signed [DIFF_W-1:0] dy);
    logic signed [DOT_W-1:0] pu;
    logic signed [DOT_W-1:0] pv;
    pu = DOT_W'(dir_u(k)) * DOT_W'(dx);
    pv = DOT_W'(dir_v(k)) * DOT_W'(dy);
    return pu + pv;
  endfunction

  function automatic logic [CH_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] d);
    logic signed [DIFF_W-1:0] a;
    a = (d < 0) ? -d : d;
    return a[CH_W-1:0];
  endfunction

endpackage

// ----- rtl/hgo_if.sv -----
// Stream interfaces of the gradient orientation core: pixel words in, result words out.
// Depends on hgo_pkg.
interface hgo_pix_if;
  logic                        valid;
  logic                        ready;
  logic [hgo_pkg::CH_W-1:0]    chan_a;
  logic [hgo_pkg::CH_W-1:0]    chan_b;
  logic [hgo_pkg::CH_W-1:0]    chan_c;

  modport source (output valid, chan_a, chan_b, chan_c, input ready);
  modport sink   (input valid, chan_a, chan_b, chan_c, output ready);
endinterface

interface hgo_res_if;
  logic                        valid;
  logic                        ready;
  logic [hgo_pkg::MAG_W-1:0]   grad_magnitude;
  logic [hgo_pkg::BIN_W-1:0]   orient_bin;

  modport source (output valid, grad_magnitude, orient_bin, input ready);
  modport sink   (input valid, grad_magnitude, orient_bin, output ready);
endinterface

// ----- rtl/hgo_win_cell.sv -----
// One column cell of the 3x3 pixel window; cells chain oldest to newest column.
// Depends on hgo_pkg.
module hgo_win_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  hgo_pkg::wcol_t col_in,
  output hgo_pkg::wcol_t col_q
);
  import hgo_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_q <= '0;
    end else if (en) begin
      col_q <= col_in;
    end
  end
endmodule

// ----- rtl/hgo_orient_cell.sv -----
// Orientation cell: tests one direction against the running best and forms the
// dot product for the next direction. Depends on hgo_pkg.
module hgo_orient_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [hgo_pkg::IDX_W-1:0] vec_idx,
  input  hgo_pkg::ocell_t           d_in,
  output hgo_pkg::ocell_t           d_q
);
  import hgo_pkg::*;

  logic signed [DOT_W:0]  dot_x;
  logic signed [DOT_W:0]  neg_x;
  logic signed [DOT_W:0]  best_x;
  logic [IDX_W-1:0]       idx_next;
  ocell_t                 d_next;

  always_comb begin
    dot_x    = {d_in.dot[DOT_W-1], d_in.dot};
    neg_x    = -dot_x;
    best_x   = {2'b00, d_in.peak_dot};
    idx_next = vec_idx + IDX_W'(1);
    d_next   = d_in;
    // positive dot wins ties against its negation
    if (dot_x > best_x) begin
      d_next.peak_dot = BEST_W'(dot_x);
      d_next.best_o   = BIN_W'(vec_idx);
    end else if (neg_x > best_x) begin
      d_next.peak_dot = BEST_W'(neg_x);
      d_next.best_o   = BIN_W'(vec_idx) + BIN_W'(DIRS);
    end
    d_next.dot = dot_of(idx_next, d_in.dx, d_in.dy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_q.valid <= 1'b0;
    end else if (en) begin
      d_q <= d_next;
    end
  end
endmodule

// ----- rtl/hog_gradient_orientation_core.sv -----
// Gradient orientation core: one pixel word per clock in, one result word per interior pixel.
// A result passes, once the pixel below-right of its centre is taken, through
// the window, difference, pick and first-dot registers, then nine orientation cells.
// Throughput is one pixel per clock; the whole pipe holds only while the output word waits.
// Synchronous reset clears counters, window and valid bits; the line store is not cleared.
// Depends on hgo_pkg, hgo_if, hgo_win_cell and hgo_orient_cell.
module hog_gradient_orientation_core (
  input  logic                        clk,
  input  logic                        rst,
  hgo_pix_if.sink                     pix_in,
  hgo_res_if.source                   res_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hgo_pkg::ADDR_W-1:0]  paddr,
  input  logic [hgo_pkg::DATA_W-1:0]  pwdata,
  output logic [hgo_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import hgo_pkg::*;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic             valid;
    logic             emit;
    logic [COL_W-1:0] col;
    pix_t             px;
  } s1_t;

  logic [WIDTH_W-1:0]   frame_width;
  logic [HEIGHT_W-1:0]  frame_height;
  logic [WIDTH_W-1:0]   w_eff;
  logic [HEIGHT_W-1:0]  h_eff;
  logic [COL_W-1:0]     col_count;
  logic [HEIGHT_W-1:0]  row_count;
  logic [WIDTH_W-1:0]   col_inc;
  logic [HEIGHT_W:0]    row_inc;
  logic                 adv;
  logic                 accept;
  logic                 s1_fire;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;
  pix_t                 px_in;

  logic [2*PIX_W-1:0]   line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0]   line_rd;

  s1_t                  s1;
  logic                 s2_valid;
  logic                 s3_valid;
  grad_t                s3_g [NCH];
  grad_t                g_next [NCH];
  logic                 s4_valid;
  grad_t                s4_g;
  grad_t                pick;
  wcol_t                wcol [3];
  wcol_t                new_col;
  ocell_t               chain [DIRS+1];

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_W'(640);
      frame_height <= HEIGHT_W'(480);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign adv          = !res_out.valid || res_out.ready;
  assign pix_in.ready = adv && !rst;
  assign accept       = pix_in.valid && pix_in.ready;
  assign s1_fire      = adv && s1.valid;
  assign px_in        = {pix_in.chan_c, pix_in.chan_b, pix_in.chan_a};

  // raster position
  always_comb begin
    if (frame_width < WIDTH_W'(3))               w_eff = WIDTH_W'(3);
    else if (frame_width > WIDTH_W'(MAX_WIDTH))  w_eff = WIDTH_W'(MAX_WIDTH);
    else                                         w_eff = frame_width;
    h_eff   = (frame_height < HEIGHT_W'(3)) ? HEIGHT_W'(3) : frame_height;
    col_inc = WIDTH_W'(col_count) + WIDTH_W'(1);
    row_inc = (HEIGHT_W+1)'(row_count) + (HEIGHT_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_inc >= w_eff) begin
        col_count <= '0;
        row_count <= (row_inc >= (HEIGHT_W+1)'(h_eff)) ? '0 : row_inc[HEIGHT_W-1:0];
      end else begin
        col_count <= col_inc[COL_W-1:0];
      end
    end
  end

  // line store: per column {newer row, older row}
  always_ff @(posedge clk) begin
    if (s1_fire) line_mem[s1.col] <= {s1.px, line_rd[2*PIX_W-1:PIX_W]};
    if (accept)  line_rd <= line_mem[col_count];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (adv) begin
      s1.valid <= accept;
      s1.emit  <= (row_count >= HEIGHT_W'(2)) && (col_count >= COL_W'(2));
      s1.col   <= col_count;
      s1.px    <= px_in;
    end
  end

  // window: chain of column cells
  assign new_col = {s1.px, line_rd[2*PIX_W-1:PIX_W], line_rd[PIX_W-1:0]};

  for (genvar i = 0; i < 3; i++) begin : g_win
    hgo_win_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (s1_fire),
      .col_in ((i == 2) ? new_col : wcol[(i + 1) % 3]),
      .col_q  (wcol[i])
    );
  end

  // per-channel central differences
  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      g_next[ch].dx  = $signed({1'b0, wcol[2][1][ch*CH_W +: CH_W]})
                     - $signed({1'b0, wcol[0][1][ch*CH_W +: CH_W]});
      g_next[ch].dy  = $signed({1'b0, wcol[1][2][ch*CH_W +: CH_W]})
                     - $signed({1'b0, wcol[1][0][ch*CH_W +: CH_W]});
      g_next[ch].mag = MAG_W'(abs_diff(g_next[ch].dx)) + MAG_W'(abs_diff(g_next[ch].dy));
    end
  end

  // strongest channel, earlier channel on ties
  always_comb begin
    pick = s3_g[0];
    for (int ch = 1; ch < NCH; ch++) begin
      if (s3_g[ch].mag > pick.mag) pick = s3_g[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      chain[0].valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1.valid && s1.emit;
      s3_valid <= s2_valid;
      s3_g     <= g_next;
      s4_valid <= s3_valid;
      s4_g     <= pick;
      chain[0].valid    <= s4_valid;
      chain[0].dx       <= s4_g.dx;
      chain[0].dy       <= s4_g.dy;
      chain[0].mag      <= s4_g.mag;
      chain[0].dot      <= dot_of(IDX_W'(0), s4_g.dx, s4_g.dy);
      chain[0].peak_dot <= '0;
      chain[0].best_o   <= '0;
    end
  end

  // orientation: chain of direction cells
  for (genvar k = 0; k < DIRS; k++) begin : g_orient
    hgo_orient_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .vec_idx (IDX_W'(k)),
      .d_in    (chain[k]),
      .d_q     (chain[k+1])
    );
  end

  assign res_out.valid          = chain[DIRS].valid;
  assign res_out.grad_magnitude = chain[DIRS].mag;
  assign res_out.orient_bin     = chain[DIRS].best_o;
endmodule

// ----- rtl/hgo_checker.sv -----
// Port-level checks of the gradient orientation core, bound to its top level.
// Depends on hgo_pkg and hog_gradient_orientation_core_defines.svh.
`include "hog_gradient_orientation_core_defines.svh"

module hgo_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [hgo_pkg::MAG_W-1:0]  grad_magnitude,
  input logic [hgo_pkg::BIN_W-1:0]  orient_bin
);
  import hgo_pkg::*;

  logic                     stall;
  logic                     in_range;
  logic [MAG_W+BIN_W-1:0]   res_word;

  assign stall    = out_valid && !out_ready;
  assign in_range = (orient_bin <= BIN_W'(BIN_MAX)) && (grad_magnitude <= MAG_W'(MAG_MAX));
  assign res_word = {grad_magnitude, orient_bin};

  `HGO_ASSERT_NEXT(a_out_hold, stall, out_valid, "result word dropped")
  `HGO_ASSERT_NEXT(a_out_stable, stall, $stable(res_word), "stalled result word changed")
  `HGO_ASSERT_IMP(a_range, out_valid, in_range, "result out of range")
  `HGO_ASSERT_IMP(a_zero_bin, out_valid && grad_magnitude == '0, orient_bin == '0, "bin not 0")
  `HGO_ASSERT_IMP(a_in_stall, !in_ready, stall, "input held without output stall")
endmodule

bind hog_gradient_orientation_core hgo_checker u_hgo_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (pix_in.ready),
  .out_valid      (res_out.valid),
  .out_ready      (res_out.ready),
  .grad_magnitude (res_out.grad_magnitude),
  .orient_bin     (res_out.orient_bin)
);

// ----- bench/hog_gradient_orientation_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for hog_gradient_orientation_core: pixel words in, gradient words out.
// Predicts magnitude and bin per interior pixel in a scoreboard class; needs hgo_pkg, hgo_if.
module hog_gradient_orientation_core_tb;
  import hgo_pkg::*;

  localparam logic [ADDR_W-1:0] REG_WIDTH_ADDR  = 3'd0;
  localparam logic [ADDR_W-1:0] REG_HEIGHT_ADDR = 3'd4;
  localparam int NUM_DIRS     = 9;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 760;
  localparam int NUM_DIRECTED = 24;

  localparam int DIR_COS [NUM_DIRS] = '{10000, 9397, 7660, 5000, 1736, -1736, -5000, -7660, -9397};
  localparam int DIR_SIN [NUM_DIRS] = '{0, 3420, 6428, 8660, 9848, 9848, 8660, 6428, 3420};

  // width 3: rows of three pixels, packed {c, b, a}
  localparam pix_t DIRECTED_PIX [NUM_DIRECTED] = '{
    24'h000000, 24'h000000, 24'h000000,
    24'h000000, 24'h000000, 24'h000000,
    24'h000000, 24'h000000, 24'hffffff,
    24'hffffff, 24'h0000ff, 24'h000000,
    24'h1e140a, 24'h000000, 24'h1e140a,
    24'h320000, 24'h0028ff, 24'h001e00,
    24'h8000ff, 24'h001400, 24'h7fff00,
    24'h030201, 24'hff0000, 24'hfcfdfe
  };

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [BIN_W-1:0] bin;
  } grad_word_t;

  class grad_scoreboard;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    pix_t                line_mem [2*MAX_WIDTH];
    pix_t                win [9];
    int                  col;
    int                  row;
    grad_word_t          grad_q [$];
    int                  errors;
    int                  pixels_taken;

    function new();
      width_reg  = 12'd640;
      height_reg = 16'd480;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i]) win[i] = '0;
      col = 0;
      row = 0;
      errors = 0;
      pixels_taken = 0;
    endfunction

    function void fail(string msg);
      if (errors < 10) $display("%s", msg);
      errors++;
    endfunction

    function int eff_width();
      int w;
      w = int'(width_reg);
      if (w < 3) w = 3;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
    endfunction

    function int eff_height();
      int h;
      h = int'(height_reg);
      if (h < 3) h = 3;
      return h;
    endfunction

    // words left until the current frame wraps
    function int frame_remaining();
      int in_row;
      in_row = eff_width() - col;
      if (in_row < 1) in_row = 1;
      if (row + 1 >= eff_height()) return in_row;
      return in_row + (eff_height() - row - 1) * eff_width();
    endfunction

    function int pending();
      return grad_q.size();
    endfunction

    function void set_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] v);
      if (addr == REG_WIDTH_ADDR) width_reg = v[WIDTH_W-1:0];
      else if (addr == REG_HEIGHT_ADDR) height_reg = v[HEIGHT_W-1:0];
    endfunction

    function void check_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] rd);
      if (addr == REG_WIDTH_ADDR) begin
        if (rd[WIDTH_W-1:0] !== width_reg)
          fail($sformatf("frame_width read: exp %0d got %0d", width_reg, rd[WIDTH_W-1:0]));
      end else begin
        if (rd[HEIGHT_W-1:0] !== height_reg)
          fail($sformatf("frame_height read: exp %0d got %0d", height_reg, rd[HEIGHT_W-1:0]));
      end
    endfunction

    function void note_pixel(pix_t p);
      int         w, h, dx, dy, mag, best_mag, bdx, bdy, dot, peak_dot;
      logic [BIN_W-1:0] best_bin;
      pix_t       older, newer;
      grad_word_t g;
      w = eff_width();
      h = eff_height();
      older = line_mem[2*col];
      newer = line_mem[2*col+1];
      for (int r = 0; r < 3; r++) begin
        win[3*r]   = win[3*r+1];
        win[3*r+1] = win[3*r+2];
      end
      win[2] = older;
      win[5] = newer;
      win[8] = p;
      line_mem[2*col]   = newer;
      line_mem[2*col+1] = p;
      pixels_taken++;
      if (row >= 2 && col >= 2) begin
        best_mag = -1;
        bdx = 0;
        bdy = 0;
        for (int ch = 0; ch < NCH; ch++) begin
          dx  = int'(win[5][CH_W*ch +: CH_W]) - int'(win[3][CH_W*ch +: CH_W]);
          dy  = int'(win[7][CH_W*ch +: CH_W]) - int'(win[1][CH_W*ch +: CH_W]);
          mag = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
          if (mag > best_mag) begin
            best_mag = mag;
            bdx = dx;
            bdy = dy;
          end
        end
        // earlier vector wins ties, positive dot before negative
        peak_dot = 0;
        best_bin = '0;
        for (int k = 0; k < NUM_DIRS; k++) begin
          dot = DIR_COS[k] * bdx + DIR_SIN[k] * bdy;
          if (dot > peak_dot) begin
            peak_dot = dot;
            best_bin = BIN_W'(k);
          end else if (-dot > peak_dot) begin
            peak_dot = -dot;
            best_bin = BIN_W'(k + NUM_DIRS);
          end
        end
        g.mag = best_mag[MAG_W-1:0];
        g.bin = best_bin;
        grad_q.push_back(g);
      end
      if (col + 1 >= w) begin
        col = 0;
        row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col++;
      end
    endfunction

    function void check_result(logic [MAG_W-1:0] mag, logic [BIN_W-1:0] bin);
      grad_word_t want;
      if (grad_q.size() == 0) begin
        fail($sformatf("unexpected result word: mag %0d bin %0d", mag, bin));
        return;
      end
      want = grad_q.pop_front();
      if (mag !== want.mag || bin !== want.bin)
        fail($sformatf("result word mismatch: mag exp %0d got %0d, bin exp %0d got %0d",
                       want.mag, mag, want.bin, bin));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  hgo_pix_if pix_if ();
  hgo_res_if res_if ();

  hog_gradient_orientation_core dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_if),
    .res_out (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  grad_scoreboard sb = new();

  int   burst_left = 0;
  int   hold_after = 32'h7fffffff;
  int   hold_left  = 0;
  bit   hold_done  = 0;
  int   rx_mode    = 0;
  int   rx_left    = 0;
  bit   rx_ready;
  pix_t prev_pix   = '0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("[hog_gradient_orientation_core] ERROR");
    $finish;
  end

  // result sink: stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready)
      sb.check_result(res_if.grad_magnitude, res_if.orient_bin);
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 128);
    end
    rx_left--;
    if (hold_left > 0) begin
      hold_left--;
      rx_ready = 1'b0;
    end else if (!hold_done && sb.pixels_taken >= hold_after) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      rx_ready = 1'b0;
    end else begin
      case (rx_mode)
        0: rx_ready = 1'b1;
        1: rx_ready = 1'($urandom_range(0, 1));
        2: rx_ready = (rx_left % 4 == 0);
        default: rx_ready = ($urandom_range(0, 9) != 0);
      endcase
    end
    res_if.ready <= rx_ready;
  end

  function automatic pix_t rand_pixel();
    pix_t p;
    logic [CH_W-1:0] g;
    p = '0;
    case ($urandom_range(0, 3))
      0: p = pix_t'($urandom);
      1: begin
        for (int ch = 0; ch < NCH; ch++) begin
          case ($urandom_range(0, 2))
            0: p[CH_W*ch +: CH_W] = '0;
            1: p[CH_W*ch +: CH_W] = '1;
            default: p[CH_W*ch +: CH_W] = CH_W'($urandom);
          endcase
        end
      end
      2: begin
        g = CH_W'($urandom);
        p = {g, g, g};
      end
      default: p = $urandom_range(0, 1) ? prev_pix : prev_pix ^ pix_t'($urandom_range(0, 3));
    endcase
    prev_pix = p;
    return p;
  endfunction

  task automatic send_pixel(input pix_t p);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid  <= 1'b1;
    pix_if.chan_a <= p[7:0];
    pix_if.chan_b <= p[15:8];
    pix_if.chan_c <= p[23:16];
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    sb.note_pixel(p);
  endtask

  task automatic run_pixels(input int n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  task automatic settle();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic [ADDR_W-1:0] addr, input bit wr,
                            input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_reg(input logic [ADDR_W-1:0] addr, input int val);
    logic [DATA_W-1:0] rd;
    settle();
    apb_access(addr, 1'b1, DATA_W'(val), rd);
    sb.set_reg(addr, DATA_W'(val));
    apb_access(addr, 1'b0, '0, rd);
    sb.check_reg(addr, rd);
  endtask

  initial begin
    logic [DATA_W-1:0] rd;
    int n, w, h;
    rst          <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    pix_if.valid  <= 1'b0;
    pix_if.chan_a <= '0;
    pix_if.chan_b <= '0;
    pix_if.chan_c <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    apb_access(REG_WIDTH_ADDR, 1'b0, '0, rd);
    sb.check_reg(REG_WIDTH_ADDR, rd);
    apb_access(REG_HEIGHT_ADDR, 1'b0, '0, rd);
    sb.check_reg(REG_HEIGHT_ADDR, rd);

    // directed: flat, full-scale, channel ties, vertical-only tie, then height cut mid-frame
    program_reg(REG_WIDTH_ADDR, 3);
    program_reg(REG_HEIGHT_ADDR, 16'hffff);
    for (int i = 0; i < NUM_DIRECTED; i++) send_pixel(DIRECTED_PIX[i]);
    program_reg(REG_HEIGHT_ADDR, 0);
    run_pixels(sb.frame_remaining());

    // width above the limit; shrink mid-row closes the row
    program_reg(REG_WIDTH_ADDR, 12'hfff);
    program_reg(REG_HEIGHT_ADDR, 3);
    run_pixels(40);
    program_reg(REG_WIDTH_ADDR, 6);
    run_pixels(sb.frame_remaining());

    // narrow tall frame with a long output hold-off
    program_reg(REG_WIDTH_ADDR, 3);
    program_reg(REG_HEIGHT_ADDR, 16'hffff);
    hold_after = sb.pixels_taken + 60;
    run_pixels(300);
    program_reg(REG_HEIGHT_ADDR, 2);
    run_pixels(sb.frame_remaining());

    n = sb.pixels_taken;
    while (sb.pixels_taken - n < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: w = $urandom_range(0, 2);
        1, 2: w = $urandom_range(25, 64);
        default: w = $urandom_range(3, 24);
      endcase
      case ($urandom_range(0, 9))
        0: h = $urandom_range(0, 2);
        1: h = $urandom_range(9, 16);
        default: h = $urandom_range(3, 8);
      endcase
      if (w > 24 && h > 4) h = $urandom_range(3, 4);
      program_reg(REG_WIDTH_ADDR, w);
      program_reg(REG_HEIGHT_ADDR, h);
      if ($urandom_range(0, 2) == 0 && sb.frame_remaining() > 2) begin
        run_pixels($urandom_range(1, sb.frame_remaining() - 1));
        if ($urandom_range(0, 1))
          program_reg(REG_WIDTH_ADDR, $urandom_range(0, sb.eff_width()));
        else
          program_reg(REG_HEIGHT_ADDR, $urandom_range(0, 20));
        run_pixels(sb.frame_remaining());
      end else begin
        run_pixels(sb.frame_remaining() * $urandom_range(1, 2));
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("[hog_gradient_orientation_core] OK");
    else
      $display("[hog_gradient_orientation_core] ERROR");
    $finish;
  end

endmodule

// ----- hog_gradient_orientation_core.f -----
+incdir+rtl
rtl/hgo_pkg.sv
rtl/hgo_if.sv
rtl/hgo_win_cell.sv
rtl/hgo_orient_cell.sv
rtl/hog_gradient_orientation_core.sv
rtl/hgo_checker.sv
bench/hog_gradient_orientation_core_tb.sv
